### sv/memory_region_coalescer_top_defines.svh
// Assertion macros shared by the checker of memory_region_coalescer_top.
// No dependencies.
`ifndef MEMORY_REGION_COALESCER_TOP_DEFINES_SVH
`define MEMORY_REGION_COALESCER_TOP_DEFINES_SVH
// Property that holds at every clock edge outside reset.
`define MRC_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// A condition that must be followed by an effect on the next clock edge.
`define MRC_ASSERT_NEXT(label, clk, rstn, cause, effect) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cause) |=> (effect)) \
    else $error("assertion failed");
`endif

### sv/mrc_pkg.sv
// Package for the memory region coalescer: widths, region record, back-engine state type.
// No dependencies.
package mrc_pkg;
  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned AddrBitsDef   = 48;
  localparam int unsigned BaseW = 48;
  localparam int unsigned SizeW = 49;
  localparam int unsigned SymW  = 16;
  localparam int unsigned SlotW = 6;

  // One accepted region, as handed from front to back.
  typedef struct packed {
    logic [BaseW-1:0] base;
    logic [BaseW-1:0] size;
    logic [BaseW-1:0] offset;
    logic [SymW-1:0]  sym;
    logic             last;
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INSERT, ST_SWEEP, ST_UPDATE, ST_EMIT
  } back_state_e;
endpackage

### sv/memory_region_coalescer_top.sv
// Top level of the memory region coalescer: front queue plus back engine.
// Depends on mrc_pkg, mrc_front, mrc_back.
//
//  channel | handshake        | fields
//  input   | start_i, busy_o  | region_base_i .. last_region_i
//  result  | valid_o strobe   | merged_base_o .. last_result_o
//
// Each region is placed by sorted insertion in the back engine. A closing region, or one
// that fills the store, starts a neighbor sweep, after which results follow at one result
// per cycle. Reset clears the state machines, counters and indices; stores need no clearing.
// busy_o stays high from a region with last_region_i set until its last result;
// results cannot stall.
module memory_region_coalescer_top #(
  parameter int unsigned MaxRegions = mrc_pkg::MaxRegionsDef,
  parameter int unsigned AddrBits   = mrc_pkg::AddrBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [mrc_pkg::BaseW-1:0] region_base_i,
  input  logic [mrc_pkg::BaseW-1:0] region_size_i,
  input  logic [mrc_pkg::BaseW-1:0] region_offset_i,
  input  logic [mrc_pkg::SymW-1:0]  symbol_index_i,
  input  logic                      last_region_i,
  output logic                      valid_o,
  output logic [mrc_pkg::BaseW-1:0] merged_base_o,
  output logic [mrc_pkg::SizeW-1:0] merged_size_o,
  output logic [mrc_pkg::BaseW-1:0] merged_offset_o,
  output logic                      has_primary_o,
  output logic [mrc_pkg::SlotW-1:0] primary_slot_o,
  output logic                      last_result_o
);
  import mrc_pkg::*;
  region_t item, q_item;
  logic q_valid, q_pop, back_busy;

  assign item = '{base: region_base_i, size: region_size_i, offset: region_offset_i,
                  sym: symbol_index_i, last: last_region_i};

  mrc_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i(item), .busy_o,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop), .back_busy_i(back_busy)
  );

  mrc_back #(.MaxRegions(MaxRegions), .AddrBits(AddrBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .busy_o(back_busy), .valid_o, .merged_base_o, .merged_size_o, .merged_offset_o,
    .has_primary_o, .primary_slot_o, .last_result_o
  );
endmodule

### sv/mrc_front.sv
// Front part: accepts regions and queues them for the back part.
// Depends on mrc_pkg.
module mrc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mrc_pkg::region_t  item_i,
  output logic              busy_o,
  output logic              q_valid_o,
  output mrc_pkg::region_t  q_item_o,
  input  logic              q_pop_i,
  input  logic              back_busy_i
);
  import mrc_pkg::*;
  // Two-entry queue. A closing region blocks further intake until the back is done.
  region_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_q, wr_d, rd_q, rd_d;
  logic hold_q, hold_d;
  logic push;

  assign busy_o    = (cnt_q == 2'd2) || hold_q;
  assign push      = start_i && !busy_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    wr_d  = wr_q ^ push;
    rd_d  = rd_q ^ q_pop_i;
    hold_d = hold_q;
    if (push && item_i.last) hold_d = 1'b1;
    else if (hold_q && cnt_q == 2'd0 && !back_busy_i && !q_pop_i) hold_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wr_q <= 1'b0; rd_q <= 1'b0; hold_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; wr_q <= wr_d; rd_q <= rd_d; hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end
endmodule

### sv/mrc_back.sv
// Back part: stores regions in base order, sweeps neighbors, emits results.
// Depends on mrc_pkg.
module mrc_back #(
  parameter int unsigned MaxRegions = mrc_pkg::MaxRegionsDef,
  parameter int unsigned AddrBits   = mrc_pkg::AddrBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  mrc_pkg::region_t              q_item_i,
  output logic                          q_pop_o,
  output logic                          busy_o,
  output logic                          valid_o,
  output logic [mrc_pkg::BaseW-1:0]     merged_base_o,
  output logic [mrc_pkg::SizeW-1:0]     merged_size_o,
  output logic [mrc_pkg::BaseW-1:0]     merged_offset_o,
  output logic                          has_primary_o,
  output logic [mrc_pkg::SlotW-1:0]     primary_slot_o,
  output logic                          last_result_o
);
  import mrc_pkg::*;
  localparam int unsigned IdxW = $clog2(MaxRegions);
  localparam int unsigned CntW = $clog2(MaxRegions + 1);
  localparam logic [BaseW-1:0] OfsMask = BaseW'((65'd1 << AddrBits) - 65'd1);

  logic [BaseW-1:0] base_q [MaxRegions];
  logic [SizeW-1:0] size_q [MaxRegions];
  logic [BaseW-1:0] ofs_q  [MaxRegions];
  logic [SymW-1:0]  sym_q  [MaxRegions];
  logic [IdxW-1:0]  prim_q [MaxRegions];
  logic [MaxRegions-1:0] pval_q;
  logic [IdxW-1:0]  ord_q  [MaxRegions];

  back_state_e st_q, st_d;
  logic [CntW-1:0] n_q;
  logic [CntW-1:0] pos_q;   // insertion position / sweep index i
  logic [CntW-1:0] k_q;     // inner index / emit index
  logic            last_q;
  logic [IdxW-1:0] best_q;
  logic            grow_q;
  logic [BaseW-1:0] gbase_q;

  logic [IdxW-1:0] nidx, pidx, kidx, sa, sb, sk;
  logic [BaseW:0]  end1, end2;
  logic            ins_shift, merge, sym_lt;
  logic [CntW-1:0] n_p1;

  assign nidx = n_q[IdxW-1:0];
  assign pidx = pos_q[IdxW-1:0];
  assign kidx = k_q[IdxW-1:0];
  assign n_p1 = n_q + CntW'(1);
  assign sa   = ord_q[pidx];
  assign sb   = ord_q[IdxW'(pos_q + CntW'(1))];
  assign sk   = ord_q[kidx];
  assign end1 = {1'b0, base_q[sa]} + size_q[sa];
  assign end2 = {1'b0, base_q[sb]} + size_q[sb];
  assign merge = {1'b0, base_q[sb]} < end1;
  assign ins_shift = (pos_q != '0) &&
                     (base_q[ord_q[IdxW'(pos_q - CntW'(1))]] > base_q[nidx]);
  assign sym_lt = sym_q[sk] < sym_q[best_q];

  assign q_pop_o = (st_q == ST_IDLE) && q_valid_i;
  assign busy_o  = st_q != ST_IDLE;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (q_valid_i) st_d = ST_INSERT;
      ST_INSERT: if (!ins_shift)
                   st_d = (last_q || n_p1 == CntW'(MaxRegions)) ? ST_SWEEP : ST_IDLE;
      ST_SWEEP:  if (pos_q + CntW'(1) >= n_q) st_d = ST_EMIT;
                 else if (merge) st_d = ST_UPDATE;
      ST_UPDATE: if (k_q == pos_q + CntW'(1)) st_d = ST_SWEEP;
      ST_EMIT:   if (k_q + CntW'(1) == n_q) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; n_q <= '0; pos_q <= '0; k_q <= '0; valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      valid_o <= (st_q == ST_EMIT);
      unique case (st_q)
        ST_IDLE: if (q_valid_i) begin
          pos_q <= n_q;
          last_q <= q_item_i.last;
          base_q[nidx] <= q_item_i.base;
          size_q[nidx] <= {1'b0, q_item_i.size};
          ofs_q[nidx]  <= q_item_i.offset & OfsMask;
          sym_q[nidx]  <= q_item_i.sym;
          pval_q[nidx] <= 1'b0;
        end
        ST_INSERT: begin
          if (ins_shift) begin
            ord_q[pidx] <= ord_q[IdxW'(pos_q - CntW'(1))];
            pos_q <= pos_q - CntW'(1);
          end else begin
            ord_q[pidx] <= nidx;
            n_q <= n_p1;
            pos_q <= '0;
          end
        end
        ST_SWEEP: begin
          k_q <= '0;
          if (pos_q + CntW'(1) < n_q) begin
            if (merge) begin
              gbase_q <= base_q[sa];
              best_q <= sb;
              grow_q <= end2 > end1;
              if (end2 > end1) size_q[sb] <= SizeW'(end2 - {1'b0, base_q[sa]});
              else size_q[sb] <= size_q[sa];
              ofs_q[sb] <= (ofs_q[sb] + (base_q[sb] - base_q[sa])) & OfsMask;
              base_q[sb] <= base_q[sa];
            end else begin
              pos_q <= pos_q + CntW'(1);
            end
          end
        end
        ST_UPDATE: begin
          // Walk members k<=i for size and best; one extra step writes pointers.
          if (k_q <= pos_q) begin
            if (base_q[sk] == gbase_q) begin
              if (grow_q) size_q[sk] <= size_q[sb];
              if (sym_lt) best_q <= sk;
            end
            k_q <= k_q + CntW'(1);
          end else begin
            // Final pass: point every member (including b) at best.
            for (int j = 0; j < MaxRegions; j++) begin
              if (CntW'(j) < n_q && base_q[j] == gbase_q &&
                  ({1'b0, IdxW'(j)} != {1'b0, IdxW'(0)} || 1'b1)) begin
                prim_q[j] <= best_q;
                pval_q[j] <= IdxW'(j) != best_q;
              end
            end
            pos_q <= pos_q + CntW'(1);
          end
        end
        ST_EMIT: begin
          merged_base_o   <= base_q[kidx];
          merged_size_o   <= size_q[kidx];
          merged_offset_o <= ofs_q[kidx];
          has_primary_o   <= pval_q[kidx];
          primary_slot_o  <= pval_q[kidx] ? SlotW'(prim_q[kidx]) : '0;
          last_result_o   <= k_q + CntW'(1) == n_q;
          k_q <= k_q + CntW'(1);
          if (k_q + CntW'(1) == n_q) n_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

### sv/mrc_checker.sv
// Port-level checker for memory_region_coalescer_top, bound to it below.
// Depends on memory_region_coalescer_top_defines.svh.
`include "memory_region_coalescer_top_defines.svh"
module mrc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic valid_o,
  input logic has_primary_o,
  input logic [5:0] primary_slot_o,
  input logic last_result_o,
  input logic start_i,
  input logic last_region_i
);
  // The last result of a set is never directly followed by another result.
  `MRC_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, valid_o && last_result_o, !valid_o)
  // Slot is zero whenever no primary is reported.
  `MRC_ASSERT(a_slot_zero, clk_i, rst_ni, (valid_o && !has_primary_o) |-> primary_slot_o == 6'd0)
  // A closing transfer shuts intake on the next cycle.
  `MRC_ASSERT_NEXT(a_close, clk_i, rst_ni, start_i && !busy_o && last_region_i, busy_o)
endmodule

bind memory_region_coalescer_top mrc_checker u_chk (
  .clk_i, .rst_ni, .busy_o, .valid_o, .has_primary_o, .primary_slot_o,
  .last_result_o, .start_i, .last_region_i
);
